// ----- design/rle8_bitmap_decoder_unit_macros.svh -----
// Assertion macros for the RLE8 bitmap decoder checker.
// Depends on nothing; included by the checker file.
`ifndef RLE8_BITMAP_DECODER_UNIT_MACROS_SVH
`define RLE8_BITMAP_DECODER_UNIT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define RLE8BD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on the following clock edge.
`define RLE8BD_ASSERT_NEXT(label, ante, cons, msg) \
  `RLE8BD_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- design/rle8bd_pkg.sv -----
// Shared types and constants of the RLE8 bitmap decoder.
// No dependencies; used by every module of the block.
package rle8bd_pkg;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned POS_W     = 13;
  localparam int unsigned BOUND_W   = 17;
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd1;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_VALUE   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_LITERAL = 3'd3,
    PH_PAD     = 3'd4,
    PH_HALT    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_RUN    = 3'd0,
    KIND_EOL    = 3'd1,
    KIND_EOB    = 3'd2,
    KIND_COLOVF = 3'd3,
    KIND_ROWOVF = 3'd4,
    KIND_DELTA  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  run_length;
    logic [7:0]  pixel_value;
  } out_word_t;

  typedef struct packed {
    logic      vld;
    out_word_t word;
  } result_t;

endpackage

// ----- design/rle8_bitmap_decoder_unit.sv -----
// Top level of the RLE8 bitmap decoder.
// Depends on rle8bd_pkg, rle8bd_parse and rle8bd_out_reg.
//
// Usage:
//   Input channel (in_valid/in_stall/in_word) takes one compressed byte per
//   word, with a frame_start flag that restarts row, column and phase.
//   Result channel (out_valid/out_stall/out_word) gives run descriptors,
//   end-of-line and end-of-bitmap markers, and overflow or delta errors.
//   Configuration: cfg_we with cfg_index 0 writes row_width, index 1
//   row_count; write only while the block is idle.
// Timing:
//   A byte is captured in an input register and parsed once the output
//   register can take its result; that result, if any, lands in the output
//   register, which drives out_valid. One byte per cycle is sustained while
//   out_stall is low; the rate is set by the single parse step per byte.
// Reset: rst_n clears phase, positions and both valid flags; the bounds
//   return to 4096. No result is shown after reset until bytes arrive.
// Stall: a stalled result holds the output register; the parser then waits
//   and the input register raises in_stall once it holds a byte.
module rle8_bitmap_decoder_unit #(
  parameter int unsigned MAX_WIDTH  = rle8bd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rle8bd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rle8bd_pkg::in_word_t                in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rle8bd_pkg::out_word_t               out_word,
  input  logic                                cfg_we,
  input  logic [rle8bd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rle8bd_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam logic [rle8bd_pkg::BOUND_W-1:0] MAX_W_B = rle8bd_pkg::BOUND_W'(MAX_WIDTH);
  localparam logic [rle8bd_pkg::BOUND_W-1:0] MAX_H_B = rle8bd_pkg::BOUND_W'(MAX_HEIGHT);

  logic [rle8bd_pkg::CFG_W-1:0] row_width_r, row_count_r;
  logic [rle8bd_pkg::BOUND_W-1:0] col_bound, row_bound;

  rle8bd_pkg::in_word_t item_r;
  logic                 item_vld_r, item_vld_nxt;
  logic                 in_accept, fire, slot_free;
  rle8bd_pkg::result_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= rle8bd_pkg::CFG_RESET;
      row_count_r <= rle8bd_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rle8bd_pkg::REG_ROW_WIDTH: row_width_r <= cfg_wdata;
        rle8bd_pkg::REG_ROW_COUNT: row_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_bound = rle8bd_pkg::BOUND_W'(row_width_r);
    if (col_bound > MAX_W_B) begin
      col_bound = MAX_W_B;
    end
    row_bound = rle8bd_pkg::BOUND_W'(row_count_r);
    if (row_bound > MAX_H_B) begin
      row_bound = MAX_H_B;
    end
  end

  // parse the held byte whenever the result slot can take its word
  assign fire      = item_vld_r && slot_free;
  assign in_stall  = item_vld_r && !slot_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (fire) begin
      item_vld_nxt = 1'b0;
    end
    if (in_accept) begin
      item_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_word;
    end
  end

  rle8bd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .col_bound (col_bound),
    .row_bound (row_bound),
    .res       (res)
  );

  rle8bd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .slot_free (slot_free)
  );

endmodule

// ----- design/rle8bd_parse.sv -----
// Byte parser of the RLE8 decoder: phase, position and literal state.
// Depends on rle8bd_pkg. Produces at most one result word per byte.
module rle8bd_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  rle8bd_pkg::in_word_t        item,
  input  logic [rle8bd_pkg::BOUND_W-1:0] col_bound,
  input  logic [rle8bd_pkg::BOUND_W-1:0] row_bound,
  output rle8bd_pkg::result_t         res
);

  rle8bd_pkg::phase_t phase_r, phase_nxt;
  logic [rle8bd_pkg::POS_W-1:0] row_r, row_nxt;
  logic [rle8bd_pkg::POS_W-1:0] col_r, col_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] lit_r, lit_nxt;
  logic       pad_r, pad_nxt;

  rle8bd_pkg::phase_t phase_e;
  logic [rle8bd_pkg::POS_W-1:0] row_e, col_e;
  logic [7:0] held_e, lit_e, lit_dec;
  logic       pad_e;
  logic       row_ovf;
  logic       run_col_ovf, lit_col_ovf;
  logic [7:0] b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rle8bd_pkg::PH_COUNT;
      row_r   <= '0;
      col_r   <= '0;
      held_r  <= '0;
      lit_r   <= '0;
      pad_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      held_r  <= held_nxt;
      lit_r   <= lit_nxt;
      pad_r   <= pad_nxt;
    end
  end

  always_comb begin
    b = item.data_byte;
    // frame start clears everything before the byte is parsed
    if (item.frame_start) begin
      phase_e = rle8bd_pkg::PH_COUNT;
      row_e   = '0;
      col_e   = '0;
      held_e  = '0;
      lit_e   = '0;
      pad_e   = 1'b0;
    end else begin
      phase_e = phase_r;
      row_e   = row_r;
      col_e   = col_r;
      held_e  = held_r;
      lit_e   = lit_r;
      pad_e   = pad_r;
    end

    row_ovf     = rle8bd_pkg::BOUND_W'(row_e) >= row_bound;
    run_col_ovf = (rle8bd_pkg::BOUND_W'(col_e) + rle8bd_pkg::BOUND_W'(held_e)) > col_bound;
    lit_col_ovf = rle8bd_pkg::BOUND_W'(col_e) >= col_bound;
    lit_dec     = (lit_e != 8'd0) ? lit_e - 8'd1 : lit_e;

    phase_nxt = phase_e;
    row_nxt   = row_e;
    col_nxt   = col_e;
    held_nxt  = held_e;
    lit_nxt   = lit_e;
    pad_nxt   = pad_e;

    res.vld              = 1'b0;
    res.word.kind        = rle8bd_pkg::KIND_RUN;
    res.word.row         = row_e[11:0];
    res.word.column      = col_e[11:0];
    res.word.run_length  = 8'd0;
    res.word.pixel_value = 8'd0;

    unique case (phase_e)
      rle8bd_pkg::PH_COUNT: begin
        if (b == 8'd0) begin
          phase_nxt = rle8bd_pkg::PH_ESCAPE;
        end else begin
          held_nxt  = b;
          phase_nxt = rle8bd_pkg::PH_VALUE;
        end
      end
      rle8bd_pkg::PH_VALUE: begin
        res.vld = 1'b1;
        if (row_ovf) begin
          res.word.kind = rle8bd_pkg::KIND_ROWOVF;
          phase_nxt     = rle8bd_pkg::PH_HALT;
        end else if (run_col_ovf) begin
          res.word.kind = rle8bd_pkg::KIND_COLOVF;
          phase_nxt     = rle8bd_pkg::PH_HALT;
        end else begin
          res.word.run_length  = held_e;
          res.word.pixel_value = b;
          col_nxt   = col_e + rle8bd_pkg::POS_W'(held_e);
          phase_nxt = rle8bd_pkg::PH_COUNT;
        end
      end
      rle8bd_pkg::PH_ESCAPE: begin
        case (b)
          rle8bd_pkg::ESC_EOL: begin
            res.vld       = 1'b1;
            res.word.kind = rle8bd_pkg::KIND_EOL;
            // saturate the row at its bound
            if (!row_ovf) begin
              row_nxt = row_e + rle8bd_pkg::POS_W'(1);
            end
            col_nxt   = '0;
            phase_nxt = rle8bd_pkg::PH_COUNT;
          end
          rle8bd_pkg::ESC_EOB: begin
            res.vld       = 1'b1;
            res.word.kind = rle8bd_pkg::KIND_EOB;
            phase_nxt     = rle8bd_pkg::PH_HALT;
          end
          rle8bd_pkg::ESC_DELTA: begin
            res.vld       = 1'b1;
            res.word.kind = rle8bd_pkg::KIND_DELTA;
            phase_nxt     = rle8bd_pkg::PH_HALT;
          end
          default: begin
            lit_nxt   = b;
            pad_nxt   = b[0];
            phase_nxt = rle8bd_pkg::PH_LITERAL;
          end
        endcase
      end
      rle8bd_pkg::PH_LITERAL: begin
        res.vld = 1'b1;
        if (row_ovf) begin
          res.word.kind = rle8bd_pkg::KIND_ROWOVF;
          phase_nxt     = rle8bd_pkg::PH_HALT;
        end else if (lit_col_ovf) begin
          res.word.kind = rle8bd_pkg::KIND_COLOVF;
          phase_nxt     = rle8bd_pkg::PH_HALT;
        end else begin
          res.word.run_length  = 8'd1;
          res.word.pixel_value = b;
          col_nxt = col_e + rle8bd_pkg::POS_W'(1);
          lit_nxt = lit_dec;
          if (lit_dec == 8'd0) begin
            phase_nxt = pad_e ? rle8bd_pkg::PH_PAD : rle8bd_pkg::PH_COUNT;
          end
        end
      end
      rle8bd_pkg::PH_PAD: begin
        // drop the pad byte whatever its value
        pad_nxt   = 1'b0;
        phase_nxt = rle8bd_pkg::PH_COUNT;
      end
      default: begin
        // halted: ignore bytes until the next frame start
      end
    endcase
  end

endmodule

// ----- design/rle8bd_out_reg.sv -----
// Result register of the RLE8 decoder, holding one word for the receiver.
// Depends on rle8bd_pkg.
module rle8bd_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  rle8bd_pkg::result_t    res,
  input  logic                   out_stall,
  output logic                   out_valid,
  output rle8bd_pkg::out_word_t  out_word,
  output logic                   slot_free
);

  logic                  vld_r, vld_nxt;
  rle8bd_pkg::out_word_t word_r;
  logic                  load;

  assign slot_free = !vld_r || !out_stall;
  assign load      = fire && res.vld;

  always_comb begin
    vld_nxt = vld_r;
    if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= res.word;
    end
  end

  assign out_valid = vld_r;
  assign out_word  = word_r;

endmodule

// ----- design/rle8bd_checker.sv -----
// Port-level checker of the RLE8 decoder, bound to the top level.
// Depends on rle8bd_pkg and rle8_bitmap_decoder_unit_macros.svh.
`include "rle8_bitmap_decoder_unit_macros.svh"

module rle8bd_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input rle8bd_pkg::out_word_t out_word
);

  `RLE8BD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")
  `RLE8BD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled word changed")
  `RLE8BD_ASSERT(a_kind_legal, out_valid |-> (out_word.kind <= rle8bd_pkg::KIND_DELTA), "bad kind")
  `RLE8BD_ASSERT(a_marker_empty, out_valid && (out_word.kind != rle8bd_pkg::KIND_RUN) |-> (out_word.run_length == 8'd0) && (out_word.pixel_value == 8'd0), "marker carries payload")
  `RLE8BD_ASSERT(a_run_nonzero, out_valid && (out_word.kind == rle8bd_pkg::KIND_RUN) |-> (out_word.run_length != 8'd0), "empty run")

endmodule

bind rle8_bitmap_decoder_unit rle8bd_checker u_rle8bd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ----- tb/rle8bd_check_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the RLE8 bitmap decoder: decodes each accepted byte on its own
// and checks every result word against the oldest one due. Depends on rle8bd_pkg.
package rle8bd_check_pkg;
  import rle8bd_pkg::*;

  class bitmap_run_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] count_reg;
    phase_t           phase;
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [7:0]       held_count;
    logic [7:0]       literal_left;
    logic             pad_pending;
    out_word_t        runs_due[$];
    int unsigned      mismatches;

    function new();
      width_reg  = CFG_RESET;
      count_reg  = CFG_RESET;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase        = PH_COUNT;
      row_pos      = 0;
      col_pos      = 0;
      held_count   = '0;
      literal_left = '0;
      pad_pending  = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_ROW_WIDTH) begin
        width_reg = value;
      end else if (idx == REG_ROW_COUNT) begin
        count_reg = value;
      end
    endfunction

    function int unsigned col_bound();
      return (width_reg < DEF_MAX_WIDTH) ? int'(width_reg) : DEF_MAX_WIDTH;
    endfunction

    function int unsigned row_bound();
      return (count_reg < DEF_MAX_HEIGHT) ? int'(count_reg) : DEF_MAX_HEIGHT;
    endfunction

    function void due_word(kind_t k, logic [7:0] len, logic [7:0] val);
      out_word_t w;
      w.kind        = k;
      w.row         = 12'(row_pos);
      w.column      = 12'(col_pos);
      w.run_length  = len;
      w.pixel_value = val;
      runs_due.push_back(w);
    endfunction

    // Row check first, then column; either one halts the frame.
    function bit write_blocked(int unsigned len);
      if (row_pos >= row_bound()) begin
        due_word(KIND_ROWOVF, '0, '0);
        phase = PH_HALT;
        return 1'b1;
      end
      if (col_pos + len > col_bound()) begin
        due_word(KIND_COLOVF, '0, '0);
        phase = PH_HALT;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Returns 0 when the byte is dropped by a halted decoder.
    function bit decode_byte(in_word_t w);
      logic [7:0] b;
      b = w.data_byte;
      if (w.frame_start) clear_frame();
      case (phase)
        PH_COUNT: begin
          if (b == 8'd0) begin
            phase = PH_ESCAPE;
          end else begin
            held_count = b;
            phase      = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (!write_blocked(held_count)) begin
            due_word(KIND_RUN, held_count, b);
            col_pos += held_count;
            phase = PH_COUNT;
          end
        end
        PH_ESCAPE: begin
          if (b == ESC_EOL) begin
            due_word(KIND_EOL, '0, '0);
            if (row_pos < row_bound()) row_pos++;
            col_pos = 0;
            phase   = PH_COUNT;
          end else if (b == ESC_EOB) begin
            due_word(KIND_EOB, '0, '0);
            phase = PH_HALT;
          end else if (b == ESC_DELTA) begin
            due_word(KIND_DELTA, '0, '0);
            phase = PH_HALT;
          end else begin
            literal_left = b;
            pad_pending  = b[0];
            phase        = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          if (!write_blocked(1)) begin
            due_word(KIND_RUN, 8'd1, b);
            col_pos++;
            if (literal_left != 8'd0) literal_left--;
            if (literal_left == 8'd0) phase = pad_pending ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD: begin
          pad_pending = 1'b0;
          phase       = PH_COUNT;
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function string word_text(out_word_t w);
      return $sformatf("kind %0d row %0d col %0d len %0d val %0d",
                       w.kind, w.row, w.column, w.run_length, w.pixel_value);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (runs_due.size() == 0) begin
        report_mismatch({"word with nothing due: ", word_text(got)});
        return;
      end
      want = runs_due.pop_front();
      if (got.kind !== want.kind || got.row !== want.row || got.column !== want.column ||
          got.run_length !== want.run_length || got.pixel_value !== want.pixel_value) begin
        report_mismatch({"got ", word_text(got), ", want ", word_text(want)});
      end
    endtask
  endclass

endpackage

// ----- tb/rle8_bitmap_decoder_unit_test.sv -----
`timescale 1ns / 100ps
// Top of the RLE8 bitmap decoder test: drives compressed byte frames under
// several bounds and idle mixes. Depends on rle8bd_pkg and rle8bd_check_pkg.
module rle8_bitmap_decoder_unit_test;
  import rle8bd_pkg::*;
  import rle8bd_check_pkg::*;

  localparam logic [7:0]  ESC_MARK    = 8'h00;
  localparam int unsigned ITEM_GOAL   = 1650;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  bitmap_run_scoreboard sb;
  int unsigned          live_bytes    = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct     = 0;
  logic                 hold_on       = 1'b0;
  logic                 frame_open    = 1'b0;
  int unsigned          cycle_count   = 0;

  rle8_bitmap_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rle8_bitmap_decoder_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs);
    in_word_t w;
    w.data_byte   = b;
    w.frame_start = fs;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.decode_byte(w)) live_bytes++;
  endtask

  // First byte of a frame carries frame_start.
  task automatic frame_byte(input logic [7:0] b);
    send_byte(b, frame_open);
    frame_open = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every due word, then let the pipeline empty.
  task automatic settle(input int unsigned tail);
    in_valid <= 1'b0;
    while (sb.runs_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    hold_on <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned cb);
    int unsigned col_est, n_cmd, pick, r, cnt, lim, n_lit, sent_lit, k;
    bit          ended;
    col_est    = 0;
    ended      = 1'b0;
    frame_open = 1'b1;
    lim        = (cb / 4 > 255) ? 255 : ((cb / 4 == 0) ? 1 : cb / 4);
    pick       = $urandom_range(99);
    if (pick < 10) begin
      // noise, with a stray frame start now and then
      n_cmd = $urandom_range(4, 16);
      repeat (n_cmd) begin
        frame_open = frame_open | ($urandom_range(7) == 0);
        frame_byte(rand_byte());
      end
    end else if (pick < 20) begin
      // fill the row right up to the column bound
      while (col_est < cb) begin
        cnt = cb - col_est;
        if (cnt > 255) cnt = $urandom_range(128, 255);
        frame_byte(8'(cnt));
        frame_byte(rand_byte());
        col_est += cnt;
      end
      if ($urandom_range(1) != 0) begin
        frame_byte(8'd1);
        frame_byte(rand_byte());
      end else begin
        frame_byte(ESC_MARK);
        frame_byte(ESC_EOL);
        frame_byte(ESC_MARK);
        frame_byte(ESC_EOB);
      end
    end else begin
      n_cmd = $urandom_range(2, 24);
      for (k = 0; k < n_cmd && !ended; k++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          r   = $urandom_range(99);
          cnt = (cb > col_est) ? cb - col_est + $urandom_range(1) : 0;
          if (r >= 35 || cnt == 0 || cnt > 255) cnt = $urandom_range(1, lim);
          if (r < 15) cnt = 255;
          frame_byte(8'(cnt));
          frame_byte(rand_byte());
          col_est += cnt;
        end else if (pick < 60) begin
          frame_byte(ESC_MARK);
          frame_byte(ESC_EOL);
          col_est = 0;
        end else if (pick < 80) begin
          n_lit    = ($urandom_range(9) == 0) ? $urandom_range(9, 60) : $urandom_range(3, 8);
          sent_lit = ($urandom_range(9) == 0) ? $urandom_range(0, n_lit) : n_lit;
          frame_byte(ESC_MARK);
          frame_byte(8'(n_lit));
          repeat (sent_lit) frame_byte(rand_byte());
          if (sent_lit < n_lit) begin
            ended = 1'b1;
          end else if (n_lit % 2 != 0) begin
            // leave the pad out once in a while so the next frame cuts in
            if ($urandom_range(9) == 0) ended = 1'b1;
            else frame_byte(rand_byte());
          end
          col_est += sent_lit;
        end else if (pick < 85) begin
          frame_byte(ESC_MARK);
          frame_byte(ESC_DELTA);
          frame_byte(rand_byte());
          frame_byte(rand_byte());
          ended = 1'b1;
        end else if (pick < 93) begin
          // broken pair: stop after the first byte
          frame_byte(($urandom_range(1) != 0) ? ESC_MARK : 8'($urandom_range(1, 255)));
          ended = 1'b1;
        end else begin
          frame_byte(ESC_MARK);
          frame_byte(ESC_EOB);
          ended = 1'b1;
        end
      end
      if (!ended && $urandom_range(9) != 0) begin
        frame_byte(ESC_MARK);
        frame_byte(ESC_EOB);
      end
    end
    if ($urandom_range(4) == 0) frame_byte(rand_byte());
  endtask

  initial begin
    int unsigned ph, goal, w, h, mode;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: longest and shortest runs, line end, odd and even literals,
    // bitmap end, a byte while halted, then delta after a new frame start
    send_byte(8'd255, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(ESC_MARK, 1'b0);
    send_byte(ESC_EOL, 1'b0);
    send_byte(ESC_MARK, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(ESC_MARK, 1'b0);
    send_byte(8'd4, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(ESC_MARK, 1'b0);
    send_byte(ESC_EOB, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(ESC_MARK, 1'b1);
    send_byte(ESC_DELTA, 1'b0);

    for (ph = 0; live_bytes < ITEM_GOAL; ph++) begin
      settle(4);
      case (ph)
        0:       begin w = 4096; h = 4096; end
        1:       begin w = 4;    h = 1;    end
        2:       begin w = 16;   h = 3;    end
        3:       begin w = 0;    h = 4;    end
        4:       begin w = 4096; h = 2;    end
        5:       begin w = 64;   h = 6;    end
        6:       begin w = 1;    h = 1;    end
        7:       begin w = 8;    h = 0;    end
        8:       begin w = 24;   h = 4096; end
        9:       begin w = 128;  h = 5;    end
        default: begin w = 4 * $urandom_range(1, 1024); h = $urandom_range(1, 16); end
      endcase
      write_reg(REG_ROW_WIDTH, 13'(w));
      write_reg(REG_ROW_COUNT, 13'(h));
      mode          = ph % 4;
      send_idle_pct = (mode == 1) ? 83 : ((mode == 3) ? 14 : 0);
      stall_pct    <= (mode == 2) ? 83 : ((mode == 3) ? 14 : 0);
      // long receiver hold while bytes keep coming: the input must back up
      if (ph == 4) fork hold_receiver(400); join_none
      goal = live_bytes + PHASE_ITEMS;
      while (live_bytes < goal && live_bytes < ITEM_GOAL) send_frame((w < 4096) ? w : 4096);
    end

    settle(8);
    if (sb.mismatches == 0 && sb.runs_due.size() == 0) begin
      $display("PASS rle8_bitmap_decoder_unit");
    end else begin
      $display("FAIL rle8_bitmap_decoder_unit");
    end
    $finish;
  end

endmodule
